// ===== src/evr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evr_pkg
// Shared types and constants for the ZYX Euler vector rotator.
// ----------------------------------------------------------------------------
package evr_pkg;

  localparam int ACCEL_W = 16;
  localparam int ANGLE_W = 17;
  localparam int OUT_W   = 21;

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_BITS  = 30;
  localparam int CORDIC_XW    = 33;
  localparam int CORDIC_ZW    = 32;

  localparam logic signed [CORDIC_XW-1:0] INV_GAIN = 33'sd652032874;

  localparam logic signed [CORDIC_ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81,
    32'sd41,        32'sd20,        32'sd10,        32'sd5,
    32'sd3,         32'sd1
  };

  // angle reduction: 2^32 = 36000 * ZHI_MUL + ZLO_MUL
  localparam logic [17:0] TURN_1   = 18'd36000;
  localparam logic [17:0] TURN_2   = 18'd72000;
  localparam logic [17:0] TURN_3   = 18'd108000;
  localparam logic [15:0] QUART_1  = 16'd9000;
  localparam logic [15:0] QUART_2  = 16'd18000;
  localparam logic [15:0] QUART_3  = 16'd27000;
  localparam logic [16:0] ZHI_MUL  = 17'd119304;
  localparam logic [14:0] ZLO_MUL  = 15'd23296;
  localparam logic [14:0] HALF_TURN = 15'd18000;
  localparam logic [21:0] RECIP_1125 = 22'd3817748;
  localparam logic [10:0] DIV_1125 = 11'd1125;

  localparam int OUT_MAX = 1048575;
  localparam int OUT_MIN = -1048576;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [ACCEL_W-1:0] x;
    logic signed [ACCEL_W-1:0] y;
    logic signed [ACCEL_W-1:0] z;
  } vec_t;

endpackage

// ===== src/evr_sincos.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evr_sincos
// Angle reduction to quadrant and binary angle, then an unrolled
// 30-stage CORDIC; 36 register stages in all.
// ----------------------------------------------------------------------------
module evr_sincos #(
  parameter int CF = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_vld,
  input  logic signed [evr_pkg::ANGLE_W-1:0] angle,
  output logic                              out_vld,
  output logic signed [CF+1:0]              sn,
  output logic signed [CF+1:0]              cs
);
  import evr_pkg::*;

  localparam int CW = CF + 2;
  localparam int RD = CORDIC_BITS - CF;
  localparam logic signed [CORDIC_XW-1:0] XRND = CORDIC_XW'(1) <<< (RD - 1);

  logic [5:1] vp;
  logic [CORDIC_STEPS-1:0] vs;

  // stage 1: wrap into [0, 36000)
  logic signed [18:0] a19;
  logic [17:0]        u;
  logic [15:0]        r1;
  logic [15:0]        r_next;

  always_comb begin
    a19 = 19'(angle) + 19'sd72000;
    u   = a19[17:0];
    if (u >= TURN_3)      r_next = 16'(u - TURN_3);
    else if (u >= TURN_2) r_next = 16'(u - TURN_2);
    else if (u >= TURN_1) r_next = 16'(u - TURN_1);
    else                  r_next = u[15:0];
  end

  always_ff @(posedge clk) begin
    r1 <= r_next;
  end

  // stage 2: quadrant and remainder
  quad_t      q2, q3, q4;
  logic [13:0] t2;

  always_ff @(posedge clk) begin
    if (r1 < QUART_1) begin
      q2 <= QUAD_0; t2 <= r1[13:0];
    end else if (r1 < QUART_2) begin
      q2 <= QUAD_1; t2 <= 14'(r1 - QUART_1);
    end else if (r1 < QUART_3) begin
      q2 <= QUAD_2; t2 <= 14'(r1 - QUART_2);
    end else begin
      q2 <= QUAD_3; t2 <= 14'(r1 - QUART_3);
    end
  end

  // stage 3: z = t*ZHI + floor((t*ZLO + 18000) / 36000)
  logic [27:0] lo_num;
  logic [22:0] w3, w4;
  logic [44:0] p3;
  logic [30:0] zhi3, zhi4;

  assign lo_num = 28'(t2 * ZLO_MUL) + 28'(HALF_TURN);

  always_ff @(posedge clk) begin
    w3   <= lo_num[27:5];
    p3   <= 45'(lo_num[27:5] * RECIP_1125);
    zhi3 <= 31'(t2 * ZHI_MUL);
    q3   <= q2;
  end

  // stage 4: quotient estimate is exact or one low
  logic [12:0] qe4;
  logic [23:0] prod4;

  always_ff @(posedge clk) begin
    qe4   <= p3[44:32];
    prod4 <= 24'(p3[44:32] * DIV_1125);
    w4    <= w3;
    zhi4  <= zhi3;
    q4    <= q3;
  end

  // stage 5: correct and seed the CORDIC
  logic [23:0] rem4;
  logic [12:0] qc4;

  logic signed [CORDIC_XW-1:0] xs [0:CORDIC_STEPS];
  logic signed [CORDIC_XW-1:0] ys [0:CORDIC_STEPS];
  logic signed [CORDIC_ZW-1:0] zs [0:CORDIC_STEPS];
  quad_t                       qs [0:CORDIC_STEPS];

  always_comb begin
    rem4 = 24'(w4) - prod4;
    qc4  = (rem4 >= 24'(DIV_1125)) ? 13'(qe4 + 13'd1) : qe4;
  end

  always_ff @(posedge clk) begin
    xs[0] <= INV_GAIN;
    ys[0] <= '0;
    zs[0] <= CORDIC_ZW'(zhi4) + CORDIC_ZW'(qc4);
    qs[0] <= q4;
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (!zs[k][CORDIC_ZW-1]) begin
        xs[k+1] <= xs[k] - (ys[k] >>> k);
        ys[k+1] <= ys[k] + (xs[k] >>> k);
        zs[k+1] <= zs[k] - ATAN_TAB[k];
      end else begin
        xs[k+1] <= xs[k] + (ys[k] >>> k);
        ys[k+1] <= ys[k] - (xs[k] >>> k);
        zs[k+1] <= zs[k] + ATAN_TAB[k];
      end
      qs[k+1] <= qs[k];
    end
  end

  // final stage: round to CF fraction bits and unfold the quadrant
  logic signed [CORDIC_XW-1:0] xr, yr;
  logic signed [CW-1:0]        c_r, s_r;

  always_comb begin
    xr  = (xs[CORDIC_STEPS] + XRND) >>> RD;
    yr  = (ys[CORDIC_STEPS] + XRND) >>> RD;
    c_r = CW'(xr);
    s_r = CW'(yr);
  end

  always_ff @(posedge clk) begin
    case (qs[CORDIC_STEPS])
      QUAD_1: begin sn <= c_r;  cs <= -s_r; end
      QUAD_2: begin sn <= -s_r; cs <= -c_r; end
      QUAD_3: begin sn <= -c_r; cs <= s_r;  end
      default: begin sn <= s_r; cs <= c_r;  end
    endcase
  end

  // vs[k] travels with xs[k+1]; out_vld travels with sn/cs
  always_ff @(posedge clk) begin
    if (rst) begin
      vp      <= '0;
      vs      <= '0;
      out_vld <= 1'b0;
    end else begin
      vp      <= {vp[4:1], in_vld};
      vs      <= {vs[CORDIC_STEPS-2:0], vp[5]};
      out_vld <= vs[CORDIC_STEPS-1];
    end
  end

endmodule

// ===== src/evr_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evr_matrix
// Builds R = Rz*Ry*Rx from the sine/cosine words in three stages:
// pair products, triple products, then the entry sums.
// ----------------------------------------------------------------------------
module evr_matrix #(
  parameter int CF = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  logic signed [CF+1:0] sr,
  input  logic signed [CF+1:0] cr,
  input  logic signed [CF+1:0] sp,
  input  logic signed [CF+1:0] cp,
  input  logic signed [CF+1:0] sy,
  input  logic signed [CF+1:0] cy,
  output logic                out_vld,
  output logic signed [CF+2:0] m [9]
);
  import evr_pkg::*;

  localparam int CW = CF + 2;
  localparam int MW = CF + 3;
  localparam logic signed [2*CW-1:0] PRND = (2*CW)'(1) <<< (CF - 1);

  function automatic logic signed [CW-1:0] fmul(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    logic signed [2*CW-1:0] p;
    p = a * b;
    p = p + PRND;
    return CW'(p >>> CF);
  endfunction

  logic [1:0] vp;

  // stage A: products of two
  logic signed [CW-1:0] a_cycp, a_spsr, a_sycr, a_spcr, a_sysr;
  logic signed [CW-1:0] a_sycp, a_cycr, a_cysr, a_cpsr, a_cpcr, a_sp, a_sy, a_cy;

  always_ff @(posedge clk) begin
    a_cycp <= fmul(cy, cp);
    a_spsr <= fmul(sp, sr);
    a_sycr <= fmul(sy, cr);
    a_spcr <= fmul(sp, cr);
    a_sysr <= fmul(sy, sr);
    a_sycp <= fmul(sy, cp);
    a_cycr <= fmul(cy, cr);
    a_cysr <= fmul(cy, sr);
    a_cpsr <= fmul(cp, sr);
    a_cpcr <= fmul(cp, cr);
    a_sp   <= sp;
    a_sy   <= sy;
    a_cy   <= cy;
  end

  // stage B: three-factor terms
  logic signed [CW-1:0] b_cyss, b_cysc, b_syss, b_sysc;
  logic signed [CW-1:0] b_cycp, b_sycr, b_sysr, b_sycp, b_cycr, b_cysr, b_cpsr, b_cpcr;
  logic signed [CW-1:0] b_sp;

  always_ff @(posedge clk) begin
    b_cyss <= fmul(a_cy, a_spsr);
    b_cysc <= fmul(a_cy, a_spcr);
    b_syss <= fmul(a_sy, a_spsr);
    b_sysc <= fmul(a_sy, a_spcr);
    b_cycp <= a_cycp;
    b_sycr <= a_sycr;
    b_sysr <= a_sysr;
    b_sycp <= a_sycp;
    b_cycr <= a_cycr;
    b_cysr <= a_cysr;
    b_cpsr <= a_cpsr;
    b_cpcr <= a_cpcr;
    b_sp   <= a_sp;
  end

  // stage C: entry sums
  always_ff @(posedge clk) begin
    m[0] <= MW'(b_cycp);
    m[1] <= MW'(b_cyss) - MW'(b_sycr);
    m[2] <= MW'(b_cysc) + MW'(b_sysr);
    m[3] <= MW'(b_sycp);
    m[4] <= MW'(b_syss) + MW'(b_cycr);
    m[5] <= MW'(b_sysc) - MW'(b_cysr);
    m[6] <= -MW'(b_sp);
    m[7] <= MW'(b_cpsr);
    m[8] <= MW'(b_cpcr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp      <= '0;
      out_vld <= 1'b0;
    end else begin
      vp      <= {vp[0], in_vld};
      out_vld <= vp[1];
    end
  end

endmodule

// ===== src/evr_dot.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evr_dot
// Matrix times vector: nine products, then row sums with rounding
// and saturation to the output word.
// ----------------------------------------------------------------------------
module evr_dot #(
  parameter int CF = 16,
  parameter int OF = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_vld,
  input  logic signed [CF+2:0]            m [9],
  input  evr_pkg::vec_t                   vec,
  output logic                            out_vld,
  output logic signed [evr_pkg::OUT_W-1:0] world_x,
  output logic signed [evr_pkg::OUT_W-1:0] world_y,
  output logic signed [evr_pkg::OUT_W-1:0] world_z
);
  import evr_pkg::*;

  localparam int MW = CF + 3;
  localparam int PW = MW + ACCEL_W;
  localparam int AW = PW + 2;
  localparam int RD = CF - OF;
  localparam logic signed [AW-1:0] ARND = AW'(1) <<< (RD - 1);
  localparam logic signed [AW-1:0] SAT_HI = AW'(OUT_MAX);
  localparam logic signed [AW-1:0] SAT_LO = AW'(OUT_MIN);

  logic              vd;
  logic signed [PW-1:0] pr [9];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pr[3*i]   <= m[3*i]   * vec.x;
      pr[3*i+1] <= m[3*i+1] * vec.y;
      pr[3*i+2] <= m[3*i+2] * vec.z;
    end
  end

  logic signed [AW-1:0]    acc [3];
  logic signed [AW-1:0]    rv  [3];
  logic signed [OUT_W-1:0] sat [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = AW'(pr[3*i]) + AW'(pr[3*i+1]) + AW'(pr[3*i+2]);
      rv[i]  = (acc[i] + ARND) >>> RD;
      if (rv[i] > SAT_HI)      sat[i] = OUT_W'(SAT_HI);
      else if (rv[i] < SAT_LO) sat[i] = OUT_W'(SAT_LO);
      else                     sat[i] = OUT_W'(rv[i]);
    end
  end

  always_ff @(posedge clk) begin
    world_x <= sat[0];
    world_y <= sat[1];
    world_z <= sat[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd      <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vd      <= in_vld;
      out_vld <= vd;
    end
  end

endmodule

// ===== src/euler_zyx_vector_rotate.sv =====
`timescale 1ns / 1ps
// Throughput: one word per cycle; busy stays low, as the pipeline never stalls.
// Depth is set by the 30-stage unrolled CORDIC plus reduction, matrix and dot stages.
// Reset clears only the valid chain; results come out only for accepted words.
// ----------------------------------------------------------------------------
// euler_zyx_vector_rotate
// Rotates a body-frame acceleration word into the world frame with the ZYX
// Euler matrix built from roll, pitch and yaw in centidegrees.
// ----------------------------------------------------------------------------
module euler_zyx_vector_rotate #(
  parameter int COEF_FRAC_BITS = 16,
  parameter int OUT_FRAC_BITS  = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [evr_pkg::ACCEL_W-1:0] accel_x,
  input  logic signed [evr_pkg::ACCEL_W-1:0] accel_y,
  input  logic signed [evr_pkg::ACCEL_W-1:0] accel_z,
  input  logic signed [evr_pkg::ANGLE_W-1:0] roll_cdeg,
  input  logic signed [evr_pkg::ANGLE_W-1:0] pitch_cdeg,
  input  logic signed [evr_pkg::ANGLE_W-1:0] yaw_cdeg,
  output logic                             done,
  output logic signed [evr_pkg::OUT_W-1:0]   world_x,
  output logic signed [evr_pkg::OUT_W-1:0]   world_y,
  output logic signed [evr_pkg::OUT_W-1:0]   world_z
);
  import evr_pkg::*;

  localparam int CW = COEF_FRAC_BITS + 2;
  localparam int MW = COEF_FRAC_BITS + 3;
  localparam int VEC_DLY = 39;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  logic                 v_r, v_p, v_y;
  logic signed [CW-1:0] sr, cr, sp, cp, sy, cy;

  evr_sincos #(.CF(COEF_FRAC_BITS)) u_roll (
    .clk(clk), .rst(rst), .in_vld(accept), .angle(roll_cdeg),
    .out_vld(v_r), .sn(sr), .cs(cr)
  );

  evr_sincos #(.CF(COEF_FRAC_BITS)) u_pitch (
    .clk(clk), .rst(rst), .in_vld(accept), .angle(pitch_cdeg),
    .out_vld(v_p), .sn(sp), .cs(cp)
  );

  evr_sincos #(.CF(COEF_FRAC_BITS)) u_yaw (
    .clk(clk), .rst(rst), .in_vld(accept), .angle(yaw_cdeg),
    .out_vld(v_y), .sn(sy), .cs(cy)
  );

  logic                 m_vld;
  logic signed [MW-1:0] m [9];

  evr_matrix #(.CF(COEF_FRAC_BITS)) u_matrix (
    .clk(clk), .rst(rst), .in_vld(v_r & v_p & v_y),
    .sr(sr), .cr(cr), .sp(sp), .cp(cp), .sy(sy), .cy(cy),
    .out_vld(m_vld), .m(m)
  );

  // acceleration rides alongside the angle path
  vec_t dly [VEC_DLY];

  always_ff @(posedge clk) begin
    dly[0] <= '{x: accel_x, y: accel_y, z: accel_z};
    for (int i = 1; i < VEC_DLY; i++) begin
      dly[i] <= dly[i-1];
    end
  end

  evr_dot #(.CF(COEF_FRAC_BITS), .OF(OUT_FRAC_BITS)) u_dot (
    .clk(clk), .rst(rst), .in_vld(m_vld), .m(m), .vec(dly[VEC_DLY-1]),
    .out_vld(done), .world_x(world_x), .world_y(world_y), .world_z(world_z)
  );

endmodule
